/* rtl/xmdu_pkg.sv */
// ----------------------------------------------------------------------------
// xmdu_pkg
// Types, codes and the divide step shared by the multiply/divide unit.
// ----------------------------------------------------------------------------
package xmdu_pkg;

	localparam int NSTEP = 16;

	localparam logic [2:0] K_MUL8   = 3'd0;
	localparam logic [2:0] K_IMUL8  = 3'd1;
	localparam logic [2:0] K_MUL16  = 3'd2;
	localparam logic [2:0] K_IMUL16 = 3'd3;
	localparam logic [2:0] K_DIV8   = 3'd4;
	localparam logic [2:0] K_IDIV8  = 3'd5;
	localparam logic [2:0] K_DIV16  = 3'd6;
	localparam logic [2:0] K_IDIV16 = 3'd7;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] first_operand;
		logic [15:0] second_operand;
	} op_t;

	typedef struct packed {
		logic [15:0] ax_out;
		logic [15:0] dx_out;
		logic        dx_written;
		logic        carry_overflow;
		logic        flags_written;
		logic        divide_error;
	} res_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  kind;
		logic [31:0] prod;
		logic [15:0] rem;
		logic [15:0] nlo;
		logic [15:0] quo;
		logic [15:0] dmag;
		logic        nneg;
		logic        dneg;
		logic        ovf;
	} work_t;

	// one restoring divide step
	function automatic work_t div_step(input work_t w);
		work_t       o;
		logic [16:0] t;
		logic [16:0] diff;
		logic        ge;
		o    = w;
		t    = {w.rem, w.nlo[15]};
		diff = t - {1'b0, w.dmag};
		ge   = (t >= {1'b0, w.dmag});
		o.rem = ge ? diff[15:0] : t[15:0];
		o.nlo = {w.nlo[14:0], 1'b0};
		o.quo = {w.quo[14:0], ge};
		return o;
	endfunction

endpackage

/* rtl/x86_multiply_divide_unit.sv */
// ----------------------------------------------------------------------------
// x86_multiply_divide_unit
// 8086 mul/imul/div/idiv unit: one operand stage, sixteen divide steps, one
// result stage. The done strobe and the result are registered together from
// the last divide step; one item every cycle,
// set by the one-bit-per-stage divide chain. busy is always low.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module x86_multiply_divide_unit
	import xmdu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  op_t  operands,
	output logic done,
	output res_t result
);

	work_t       pipe_s [0:NSTEP];
	work_t       entry;
	res_t        res_d;
	logic [16:0] ma, mb;
	logic [33:0] prod_full;
	logic [31:0] nraw, nmag;
	logic [15:0] draw, dmag;
	logic        sgn, word, nneg, dneg;

	assign busy = 1'b0;
	assign sgn  = operands.kind[0];
	assign word = operands.kind[1];

	always_comb begin
		ma = word ? {sgn & operands.first_operand[15], operands.first_operand[15:0]}
		          : {{9{sgn & operands.first_operand[7]}}, operands.first_operand[7:0]};
		mb = word ? {sgn & operands.second_operand[15], operands.second_operand}
		          : {{9{sgn & operands.second_operand[7]}}, operands.second_operand[7:0]};
		prod_full = 34'($signed(ma) * $signed(mb));
		nraw = word ? operands.first_operand
		            : {{16{sgn & operands.first_operand[15]}}, operands.first_operand[15:0]};
		draw = word ? operands.second_operand
		            : {{8{sgn & operands.second_operand[7]}}, operands.second_operand[7:0]};
		nneg = sgn & nraw[31];
		dneg = sgn & draw[15];
		nmag = nneg ? 32'(-nraw) : nraw;
		dmag = dneg ? 16'(-draw) : draw;
		entry.valid = start;
		entry.kind  = operands.kind;
		entry.prod  = prod_full[31:0];
		entry.rem   = nmag[31:16];
		entry.nlo   = nmag[15:0];
		entry.quo   = '0;
		entry.dmag  = dmag;
		entry.nneg  = nneg;
		entry.dneg  = dneg;
		entry.ovf   = (nmag[31:16] >= dmag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NSTEP; i++) pipe_s[i].valid <= 1'b0;
		end else begin
			pipe_s[0] <= entry;
			for (int i = 1; i <= NSTEP; i++) pipe_s[i] <= div_step(pipe_s[i-1]);
		end
	end

	work_t       fin;
	logic [15:0] qv, rv;
	logic        qneg, qbad;

	always_comb begin
		fin   = pipe_s[NSTEP];
		qneg  = fin.nneg ^ fin.dneg;
		qv    = qneg ? 16'(-fin.quo) : fin.quo;
		rv    = fin.nneg ? 16'(-fin.rem) : fin.rem;
		res_d = '0;
		qbad  = 1'b0;
		unique case (fin.kind)
			K_MUL8: begin
				res_d.ax_out         = fin.prod[15:0];
				res_d.carry_overflow = (fin.prod[15:8] != 8'h00);
				res_d.flags_written  = 1'b1;
			end
			K_IMUL8: begin
				res_d.ax_out         = fin.prod[15:0];
				res_d.carry_overflow = (fin.prod[15:7] != 9'h000) && (fin.prod[15:7] != 9'h1FF);
				res_d.flags_written  = 1'b1;
			end
			K_MUL16: begin
				res_d.ax_out         = fin.prod[15:0];
				res_d.dx_out         = fin.prod[31:16];
				res_d.dx_written     = 1'b1;
				res_d.carry_overflow = (fin.prod[31:16] != 16'h0000);
				res_d.flags_written  = 1'b1;
			end
			K_IMUL16: begin
				res_d.ax_out         = fin.prod[15:0];
				res_d.dx_out         = fin.prod[31:16];
				res_d.dx_written     = 1'b1;
				res_d.carry_overflow = (fin.prod[31:15] != 17'h00000)
				                    && (fin.prod[31:15] != 17'h1FFFF);
				res_d.flags_written  = 1'b1;
			end
			K_DIV8, K_IDIV8: begin
				if (fin.kind[0]) qbad = qneg ? (fin.quo > 16'h0080) : (fin.quo > 16'h007F);
				else qbad = (fin.quo > 16'h00FF);
				if (fin.ovf || qbad) res_d.divide_error = 1'b1;
				else res_d.ax_out = {rv[7:0], qv[7:0]};
			end
			default: begin
				if (fin.kind[0]) qbad = qneg ? (fin.quo > 16'h8000) : (fin.quo > 16'h7FFF);
				if (fin.ovf || qbad) res_d.divide_error = 1'b1;
				else begin
					res_d.ax_out     = qv;
					res_d.dx_out     = rv;
					res_d.dx_written = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= fin.valid;
		end
	end

	always_ff @(posedge clk) begin
		result <= res_d;
	end

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n) start |-> ##18 done)
		else $error("item lost in pipeline");
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.divide_error |-> result.ax_out == 16'h0000 && !result.dx_written
		&& !result.flags_written)
		else $error("divide error with register write");
	a_dx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.dx_written |-> result.dx_out == 16'h0000)
		else $error("dx driven without write");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives mul/imul/div/idiv items into the multiply/divide unit, predicts
// each AX/DX/flag/error result and checks the done-strobed results in order.
// ----------------------------------------------------------------------------
module tb_top;
	import xmdu_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	op_t  operands;
	logic done;
	res_t result;

	op_t  pending_items[$];
	res_t expected_results[$];
	int   mismatches;
	bit   quiet_phase;
	bit   hold_for_drain;
	bit   stim_done;

	x86_multiply_divide_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operands(operands), .done(done), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic res_t muldiv_result(input op_t op);
		res_t        r;
		logic [31:0] a;
		logic [15:0] b;
		longint      n;
		longint      d;
		longint      q;
		longint      rm;
		longint      p;
		r = '0;
		a = op.first_operand;
		b = op.second_operand;
		case (op.kind)
			K_MUL8: begin
				p = longint'(a[7:0]) * longint'(b[7:0]);
				r.ax_out = p[15:0];
				r.carry_overflow = p[15:8] != 0;
				r.flags_written = 1'b1;
			end
			K_IMUL8: begin
				p = longint'($signed(a[7:0])) * longint'($signed(b[7:0]));
				r.ax_out = p[15:0];
				r.carry_overflow = (p > 127) || (p < -128);
				r.flags_written = 1'b1;
			end
			K_MUL16: begin
				p = longint'(a[15:0]) * longint'(b);
				r.ax_out = p[15:0];
				r.dx_out = p[31:16];
				r.dx_written = 1'b1;
				r.carry_overflow = p[31:16] != 0;
				r.flags_written = 1'b1;
			end
			K_IMUL16: begin
				p = longint'($signed(a[15:0])) * longint'($signed(b));
				r.ax_out = p[15:0];
				r.dx_out = p[31:16];
				r.dx_written = 1'b1;
				r.carry_overflow = (p > 32767) || (p < -32768);
				r.flags_written = 1'b1;
			end
			K_DIV8: begin
				n = longint'(a[15:0]);
				d = longint'(b[7:0]);
				if (d == 0 || n / d > 255) r.divide_error = 1'b1;
				else begin
					q = n / d;
					rm = n % d;
					r.ax_out = {rm[7:0], q[7:0]};
				end
			end
			K_IDIV8: begin
				n = longint'($signed(a[15:0]));
				d = longint'($signed(b[7:0]));
				if (d == 0) r.divide_error = 1'b1;
				else begin
					q = n / d;
					rm = n % d;
					if (q > 127 || q < -128) r.divide_error = 1'b1;
					else r.ax_out = {rm[7:0], q[7:0]};
				end
			end
			K_DIV16: begin
				n = longint'(a);
				d = longint'(b);
				if (d == 0 || n / d > 65535) r.divide_error = 1'b1;
				else begin
					q = n / d;
					rm = n % d;
					r.ax_out = q[15:0];
					r.dx_out = rm[15:0];
					r.dx_written = 1'b1;
				end
			end
			default: begin
				n = longint'($signed(a));
				d = longint'($signed(b));
				if (d == 0) r.divide_error = 1'b1;
				else begin
					q = n / d;
					rm = n % d;
					if (q > 32767 || q < -32768) r.divide_error = 1'b1;
					else begin
						r.ax_out = q[15:0];
						r.dx_out = rm[15:0];
						r.dx_written = 1'b1;
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic op_t make_item(input logic [2:0] k, input logic [31:0] a,
			input logic [15:0] b);
		op_t o;
		o.kind = k;
		o.first_operand = a;
		o.second_operand = b;
		return o;
	endfunction

	// mostly in-range divides, some random noise
	function automatic op_t random_item();
		op_t         o;
		logic [15:0] b;
		logic [15:0] q;
		logic [15:0] rm;
		o.kind = 3'($urandom_range(0, 7));
		o.first_operand = $urandom;
		o.second_operand = 16'($urandom);
		case ($urandom_range(0, 5))
			0: o.second_operand = 16'($urandom_range(0, 3));
			1: o.second_operand = {16{o.second_operand[0]}};
			2: o.first_operand[31:8] = {24{o.first_operand[7]}};
			default: ;
		endcase
		if (o.kind[2] && $urandom_range(0, 3) != 0) begin
			b = 16'($urandom);
			if (b == 0) b = 16'd1;
			q = 16'($urandom);
			rm = 16'($urandom);
			if (o.kind == K_DIV16) begin
				o.second_operand = b;
				o.first_operand = 32'(b) * 32'(q) + 32'(rm % b);
			end else if (o.kind == K_DIV8) begin
				if (b[7:0] == 0) b[0] = 1'b1;
				o.second_operand = b;
				o.first_operand = {16'($urandom), 16'(b[7:0] * q[7:0] + rm[7:0] % b[7:0])};
			end else if (o.kind == K_IDIV8) begin
				o.first_operand = {16'($urandom),
					16'($signed(b[7:0] == 0 ? 8'd3 : b[7:0]) * $signed(q[7:0]))};
				o.second_operand = {8'($urandom), (b[7:0] == 0 ? 8'd3 : b[7:0])};
			end else begin
				o.second_operand = b;
				o.first_operand = 32'($signed(b) * $signed(q));
			end
		end
		return o;
	endfunction

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		operands = '0;
		mismatches = 0;
		quiet_phase = 1'b0;
		hold_for_drain = 1'b0;
		stim_done = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		pending_items.push_back(make_item(K_MUL8, 32'hFFFF_FFFF, 16'hFFFF));
		pending_items.push_back(make_item(K_MUL8, 32'h0, 16'h0));
		pending_items.push_back(make_item(K_IMUL8, 32'h80, 16'h80));
		pending_items.push_back(make_item(K_IMUL8, 32'hFF, 16'h7F));
		pending_items.push_back(make_item(K_MUL16, 32'hFFFF_FFFF, 16'hFFFF));
		pending_items.push_back(make_item(K_IMUL16, 32'h8000, 16'h8000));
		pending_items.push_back(make_item(K_IMUL16, 32'hFFFF, 16'h7FFF));
		pending_items.push_back(make_item(K_DIV8, 32'h1234, 16'h0));
		pending_items.push_back(make_item(K_DIV8, 32'hFFFF, 16'hFF));
		pending_items.push_back(make_item(K_DIV8, 32'hFFFF_FEFF, 16'hFF01));
		pending_items.push_back(make_item(K_IDIV8, 32'hFF80, 16'h1));
		pending_items.push_back(make_item(K_IDIV8, 32'h0080, 16'hFF));
		pending_items.push_back(make_item(K_IDIV8, 32'hFFF9, 16'h2));
		pending_items.push_back(make_item(K_IDIV8, 32'h7, 16'h0));
		pending_items.push_back(make_item(K_DIV16, 32'hFFFF_FFFF, 16'hFFFF));
		pending_items.push_back(make_item(K_DIV16, 32'h0001_0000, 16'h1));
		pending_items.push_back(make_item(K_DIV16, 32'h5, 16'h0));
		pending_items.push_back(make_item(K_IDIV16, 32'hFFFF_8000, 16'h1));
		pending_items.push_back(make_item(K_IDIV16, 32'h8000_0000, 16'hFFFF));
		pending_items.push_back(make_item(K_IDIV16, 32'h0000_8000, 16'hFFFF));
		pending_items.push_back(make_item(K_IDIV16, 32'hFFFF_FFF9, 16'h2));
		pending_items.push_back(make_item(K_IDIV16, 32'h7FFF_FFFF, 16'h7FFF));
		wait (pending_items.size() == 0);
		hold_for_drain = 1'b1;
		wait (expected_results.size() == 0);
		hold_for_drain = 1'b0;
		for (int i = 0; i < 700; i++) begin
			quiet_phase = (i >= 250 && i < 400);
			pending_items.push_back(random_item());
			wait (pending_items.size() < 4);
		end
		wait (pending_items.size() == 0);
		stim_done = 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.push_back(muldiv_result(operands));
				void'(pending_items.pop_front());
			end
			if ((start && !busy) || !start) begin
				if (pending_items.size() > 0 && !hold_for_drain
						&& (quiet_phase || $urandom_range(0, 99) >= 33)) begin
					start <= 1'b1;
					operands <= pending_items[0];
				end else
					start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		res_t exp_r;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", result);
			end else begin
				exp_r = expected_results.pop_front();
				if (result !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h actual %h", exp_r, result);
				end
			end
		end
	end

	initial begin
		wait (stim_done);
		wait (expected_results.size() == 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_top failed");
		$finish;
	end

endmodule

/* files.f */
rtl/xmdu_pkg.sv
rtl/x86_multiply_divide_unit.sv
tb/tb_top.sv
